@@ sv/dts_pkg.sv @@
// dts_pkg: shared constants and types for the dominator tree solver
// no dependencies; used by the controller, datapath and top level
`timescale 1ns / 1ps
package dts_pkg;
  localparam int MaxNodes = 64;
  localparam int IdxW = 6;
  localparam int CntW = 7;
  localparam int PassW = 8;
  localparam logic [PassW-1:0] MaxPasses = 8'd128;

  localparam logic [1:0] MODE_EDGE = 2'd0;
  localparam logic [1:0] MODE_SOLVE = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic add_edge;   // latch edge, read its predecessor row
    logic wr_edge;    // write the row back with the edge bit set
    logic clr_rows;   // clear all predecessor rows
    logic init_dom;   // fresh solve: invalidate dom table, entry valid
    logic load_row;   // read pred row of block b_r
    logic take_cand;  // cand := p (first valid pred)
    logic set_a;      // a := p, c := cand for a meet
    logic rd_meet;    // read dom entry of the larger of a and c
    logic climb;      // larger of a and c := climb(it)
    logic meet_done;  // cand := a
    logic rd_b;       // read dom entry of block b
    logic write_dom;  // store cand into dom[b]
    logic rd_emit;    // read dom entry of the next result
  } dts_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic pred_ok;    // current p is a valid predecessor
    logic a_gt_c;
    logic c_gt_a;
    logic dom_diff;   // dom[b] differs from cand
  } dts_sts_t;
endpackage

@@ sv/dominator_tree_solver_core.sv @@
// dominator_tree_solver_core: top level of the immediate dominator solver
// depends on dts_pkg, dts_ctrl, dts_dp
//
//  channel | handshake             | fields
//  input   | in_valid / in_ready   | in_mode, in_block, in_pred_block
//  result  | out_valid / out_ready | out_block_index, out_immediate_dom, out_reachable, out_last
//  config  | cfg_we                | cfg_block_count
//
// edge words: row read on accept, write-back in S_EDGE with ready low; clears end on accept.
// a solve word runs passes over blocks 1..n-1 until nothing changes or 128 passes; each block
// scans its predecessor row, running each meet one climb step at a time in the single meet unit.
// results then leave at one per cycle; an output stall holds the current result.
// input is held off from accept of a solve word until the last result leaves.
// reset is synchronous: edge rows invalid, dominator table invalid, block_count 1.
`timescale 1ns / 1ps
module dominator_tree_solver_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_mode,
  input  logic [dts_pkg::IdxW-1:0]   in_block,
  input  logic [dts_pkg::IdxW-1:0]   in_pred_block,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [dts_pkg::IdxW-1:0]   out_block_index,
  output logic [dts_pkg::IdxW-1:0]   out_immediate_dom,
  output logic                       out_reachable,
  output logic                       out_last,
  input  logic                       cfg_we,
  input  logic [dts_pkg::CntW-1:0]   cfg_block_count
);
  dts_pkg::dts_cmd_t cmd;
  dts_pkg::dts_sts_t sts;
  logic [dts_pkg::CntW-1:0] count_r;
  logic busy, in_fire;
  logic [dts_pkg::IdxW-1:0] b_idx, p_idx, k_idx;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= dts_pkg::CntW'(1);
    end else if (cfg_we) begin
      count_r <= cfg_block_count;
    end
  end

  assign in_ready = !busy;
  assign in_fire = in_valid && in_ready;
  assign out_block_index = k_idx;

  dts_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .in_mode, .count(count_r), .sts, .out_ready,
    .cmd, .busy, .b_idx, .p_idx, .k_idx, .out_valid, .out_last
  );

  dts_dp u_dp (
    .clk, .rst_n, .cmd, .edge_blk(in_block), .edge_prd(in_pred_block),
    .b_idx, .p_idx, .rd_idx(k_idx), .sts,
    .rd_dom(out_immediate_dom), .rd_ok(out_reachable)
  );
endmodule

@@ sv/dts_dp.sv @@
// dts_ram: generic ram with one write port and one registered read port
// dts_dp: predecessor rows, dominator table and meet datapath; depends on dts_pkg
`timescale 1ns / 1ps
module dts_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(Depth)-1:0]   waddr,
  input  logic [Width-1:0]           wdata,
  input  logic                       re,
  input  logic [$clog2(Depth)-1:0]   raddr,
  output logic [Width-1:0]           rdata
);
  logic [Width-1:0] mem_r [Depth];
  logic [Width-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    if (re) rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;
endmodule

module dts_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dts_pkg::dts_cmd_t          cmd,
  input  logic [dts_pkg::IdxW-1:0]   edge_blk,
  input  logic [dts_pkg::IdxW-1:0]   edge_prd,
  input  logic [dts_pkg::IdxW-1:0]   b_idx,
  input  logic [dts_pkg::IdxW-1:0]   p_idx,
  input  logic [dts_pkg::IdxW-1:0]   rd_idx,
  output dts_pkg::dts_sts_t          sts,
  output logic [dts_pkg::IdxW-1:0]   rd_dom,
  output logic                       rd_ok
);
  logic [dts_pkg::MaxNodes-1:0] rv_r;
  logic [dts_pkg::MaxNodes-1:0] dvalid_r;
  logic [dts_pkg::MaxNodes-1:0] pm_q, pm_wdata, row;
  logic [dts_pkg::IdxW-1:0]     eblk_r, eprd_r;
  logic [dts_pkg::IdxW-1:0]     cand_r, a_r, c_r;
  logic [dts_pkg::IdxW-1:0]     hi_idx, up, dom_q, dom_raddr, pm_raddr;
  logic                         pm_re, dom_re;

  // one climb step up the tree
  function automatic logic [dts_pkg::IdxW-1:0] climb_f(
    input logic v, input logic [dts_pkg::IdxW-1:0] d, input logic [dts_pkg::IdxW-1:0] x);
    climb_f = (v && d < x) ? d : '0;
  endfunction

  // only the larger of a and c climbs
  assign hi_idx = (a_r > c_r) ? a_r : c_r;
  assign up = climb_f(dvalid_r[hi_idx], dom_q, hi_idx);

  // predecessor rows: read-modify-write per edge, a row without its flag reads as zero
  assign pm_re = cmd.add_edge || cmd.load_row;
  assign pm_raddr = cmd.add_edge ? edge_blk : b_idx;
  assign pm_wdata = (rv_r[eblk_r] ? pm_q : '0) |
                    ({{(dts_pkg::MaxNodes-1){1'b0}}, 1'b1} << eprd_r);
  assign row = rv_r[b_idx] ? pm_q : '0;

  dts_ram #(.Width(dts_pkg::MaxNodes), .Depth(dts_pkg::MaxNodes)) u_pm_ram (
    .clk, .we(cmd.wr_edge), .waddr(eblk_r), .wdata(pm_wdata),
    .re(pm_re), .raddr(pm_raddr), .rdata(pm_q)
  );

  // row valid flags
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr_rows) begin
      rv_r <= '0;
    end else if (cmd.wr_edge) begin
      rv_r[eblk_r] <= 1'b1;
    end
  end

  // edge word held for the write-back cycle
  always_ff @(posedge clk) begin
    if (cmd.add_edge) begin
      eblk_r <= edge_blk;
      eprd_r <= edge_prd;
    end
  end

  // dominator valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dvalid_r <= '0;
    end else if (cmd.init_dom) begin
      dvalid_r <= {{(dts_pkg::MaxNodes-1){1'b0}}, 1'b1};
    end else if (cmd.write_dom) begin
      dvalid_r[b_idx] <= 1'b1;
    end
  end

  // dominator indexes
  assign dom_re = cmd.rd_meet || cmd.rd_b || cmd.rd_emit;
  assign dom_raddr = cmd.rd_meet ? hi_idx :
                     cmd.rd_b ? b_idx : rd_idx + dts_pkg::IdxW'(1);

  dts_ram #(.Width(dts_pkg::IdxW), .Depth(dts_pkg::MaxNodes)) u_dom_ram (
    .clk, .we(cmd.write_dom), .waddr(b_idx), .wdata(cand_r),
    .re(dom_re), .raddr(dom_raddr), .rdata(dom_q)
  );

  // meet registers
  always_ff @(posedge clk) begin
    if (cmd.take_cand) cand_r <= p_idx;
    else if (cmd.meet_done) cand_r <= a_r;
    if (cmd.set_a) begin
      a_r <= p_idx;
      c_r <= cand_r;
    end else if (cmd.climb) begin
      if (a_r > c_r) a_r <= up;
      else c_r <= up;
    end
  end

  assign sts.pred_ok  = row[p_idx] && dvalid_r[p_idx];
  assign sts.a_gt_c   = a_r > c_r;
  assign sts.c_gt_a   = c_r > a_r;
  assign sts.dom_diff = !dvalid_r[b_idx] || dom_q != cand_r;
  // entry block always reports itself
  assign rd_ok  = dvalid_r[rd_idx];
  assign rd_dom = (dvalid_r[rd_idx] && rd_idx != '0) ? dom_q : '0;
endmodule

@@ sv/dts_ctrl.sv @@
// dts_ctrl: sequencer for edge load, clear, fixed-point passes and emit
// depends on dts_pkg
`timescale 1ns / 1ps
module dts_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_fire,
  input  logic [1:0]                 in_mode,
  input  logic [dts_pkg::CntW-1:0]   count,
  input  dts_pkg::dts_sts_t          sts,
  input  logic                       out_ready,
  output dts_pkg::dts_cmd_t          cmd,
  output logic                       busy,
  output logic [dts_pkg::IdxW-1:0]   b_idx,
  output logic [dts_pkg::IdxW-1:0]   p_idx,
  output logic [dts_pkg::IdxW-1:0]   k_idx,
  output logic                       out_valid,
  output logic                       out_last
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EDGE  = 4'd1;
  localparam logic [3:0] S_ROW   = 4'd2;
  localparam logic [3:0] S_SCAN  = 4'd3;
  localparam logic [3:0] S_MEET  = 4'd4;
  localparam logic [3:0] S_CLIMB = 4'd5;
  localparam logic [3:0] S_WBR   = 4'd6;
  localparam logic [3:0] S_WB    = 4'd7;
  localparam logic [3:0] S_EMIT  = 4'd8;

  logic [3:0]               state_r, state_nxt;
  logic [dts_pkg::CntW-1:0] n_r, n_nxt, b_r, b_nxt, p_r, p_nxt, k_r, k_nxt;
  logic [dts_pkg::PassW-1:0] pass_r, pass_nxt;
  logic have_r, have_nxt, chg_r, chg_nxt;
  logic [dts_pkg::CntW-1:0] n_clip;

  assign n_clip = (count > dts_pkg::CntW'(dts_pkg::MaxNodes)) ?
                  dts_pkg::CntW'(dts_pkg::MaxNodes) : count;

  // next-state logic
  always_comb begin
    state_nxt = state_r; n_nxt = n_r; b_nxt = b_r; p_nxt = p_r; k_nxt = k_r;
    pass_nxt = pass_r; have_nxt = have_r; chg_nxt = chg_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_mode)
            dts_pkg::MODE_EDGE: begin
              cmd.add_edge = 1'b1;
              state_nxt = S_EDGE;
            end
            dts_pkg::MODE_CLEAR: cmd.clr_rows = 1'b1;
            dts_pkg::MODE_SOLVE: begin
              if (n_clip != '0) begin
                cmd.init_dom = 1'b1;
                n_nxt = n_clip; pass_nxt = '0; chg_nxt = 1'b0;
                k_nxt = '0;
                if (n_clip == dts_pkg::CntW'(1)) state_nxt = S_EMIT;
                else begin b_nxt = dts_pkg::CntW'(1); state_nxt = S_ROW; end
              end
            end
            default: ;
          endcase
        end
      end
      S_EDGE: begin
        cmd.wr_edge = 1'b1;
        state_nxt = S_IDLE;
      end
      S_ROW: begin
        cmd.load_row = 1'b1;
        p_nxt = '0; have_nxt = 1'b0; state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (p_r == n_r) begin
          state_nxt = S_WBR;
        end else if (sts.pred_ok && !have_r) begin
          cmd.take_cand = 1'b1; have_nxt = 1'b1; p_nxt = p_r + 1'b1;
        end else if (sts.pred_ok) begin
          cmd.set_a = 1'b1; state_nxt = S_MEET;
        end else begin
          p_nxt = p_r + 1'b1;
        end
      end
      S_MEET: begin
        if (sts.a_gt_c || sts.c_gt_a) begin
          cmd.rd_meet = 1'b1; state_nxt = S_CLIMB;
        end else begin
          cmd.meet_done = 1'b1; p_nxt = p_r + 1'b1; state_nxt = S_SCAN;
        end
      end
      S_CLIMB: begin
        cmd.climb = 1'b1; state_nxt = S_MEET;
      end
      S_WBR: begin
        cmd.rd_b = 1'b1; state_nxt = S_WB;
      end
      S_WB: begin
        if (have_r && sts.dom_diff) begin
          cmd.write_dom = 1'b1; chg_nxt = 1'b1;
        end
        if (b_r + 1'b1 < n_r) begin
          b_nxt = b_r + 1'b1; state_nxt = S_ROW;
        end else begin
          pass_nxt = pass_r + 1'b1;
          if ((chg_r || (have_r && sts.dom_diff)) && pass_r + 1'b1 < dts_pkg::MaxPasses) begin
            chg_nxt = 1'b0; b_nxt = dts_pkg::CntW'(1); state_nxt = S_ROW;
          end else state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_ready) begin
          if (k_r + 1'b1 == n_r) state_nxt = S_IDLE;
          else begin
            k_nxt = k_r + 1'b1; cmd.rd_emit = 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    n_r <= n_nxt; b_r <= b_nxt; p_r <= p_nxt; k_r <= k_nxt;
    pass_r <= pass_nxt; have_r <= have_nxt; chg_r <= chg_nxt;
  end

  assign busy = state_r != S_IDLE;
  assign b_idx = b_r[dts_pkg::IdxW-1:0];
  assign p_idx = p_r[dts_pkg::IdxW-1:0];
  assign k_idx = k_r[dts_pkg::IdxW-1:0];
  assign out_valid = state_r == S_EMIT;
  assign out_last = (k_r + 1'b1) == n_r;

`ifndef NO_ASSERTIONS
  a_one_wr: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.write_dom && cmd.init_dom)) else $error("dom write collides with init");
  a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT && !out_ready |=> state_r == S_EMIT && $stable(k_r))
    else $error("emit index moved under stall");
  a_scan_rng: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> p_r <= n_r && b_r < n_r) else $error("scan index out of range");
`endif
endmodule

@@ test/dominator_tree_solver_core_test.sv @@
// dominator_tree_solver_core_test: self-checking bench for the dominator tree solver
// depends on dts_pkg and dominator_tree_solver_core; predicts every result word itself
`timescale 1ns / 1ps
module dominator_tree_solver_core_test;
  localparam logic [1:0] ModeUnused = 2'd3;

  typedef struct packed {
    logic [dts_pkg::IdxW-1:0] blk;
    logic [dts_pkg::IdxW-1:0] idom;
    logic                     reach;
    logic                     last;
  } dom_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_mode = dts_pkg::MODE_EDGE;
  logic [dts_pkg::IdxW-1:0] in_block = '0;
  logic [dts_pkg::IdxW-1:0] in_pred_block = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [dts_pkg::IdxW-1:0] out_block_index;
  logic [dts_pkg::IdxW-1:0] out_immediate_dom;
  logic out_reachable;
  logic out_last;
  logic cfg_we = 1'b0;
  logic [dts_pkg::CntW-1:0] cfg_block_count = '0;

  // predictor state
  logic [63:0] pred_rows [dts_pkg::MaxNodes];
  logic [6:0]  idom_table [dts_pkg::MaxNodes];
  logic [dts_pkg::CntW-1:0] node_count;
  dom_word_t idom_queue [$];

  int errors = 0;
  int words_sent = 0;
  int results_seen = 0;
  int solves_sent = 0;
  int hold_cycles = 0;

  dominator_tree_solver_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_mode(in_mode),
    .in_block(in_block), .in_pred_block(in_pred_block),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_block_index(out_block_index), .out_immediate_dom(out_immediate_dom),
    .out_reachable(out_reachable), .out_last(out_last),
    .cfg_we(cfg_we), .cfg_block_count(cfg_block_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // one step up the tree, falling to the entry when no progress is made
  function automatic int climb_up(int x);
    int d;
    if (idom_table[x][6] == 1'b0) return 0;
    d = int'(idom_table[x][5:0]);
    if (d >= x) return 0;
    return d;
  endfunction

  function automatic int meet(int a, int c);
    while (a != c) begin
      while (a > c) a = climb_up(a);
      while (c > a) c = climb_up(c);
    end
    return a;
  endfunction

  // fixed point over blocks 1..n-1, then queue one word per block
  task automatic predict_idoms();
    int n, pass, b, p, cand;
    bit changed, have;
    logic [6:0] v;
    dom_word_t w;
    n = (int'(node_count) > dts_pkg::MaxNodes) ? dts_pkg::MaxNodes : int'(node_count);
    if (n == 0) return;
    for (int i = 0; i < dts_pkg::MaxNodes; i++) idom_table[i] = '0;
    idom_table[0] = 7'h40;
    changed = 1'b1;
    for (pass = 0; changed && pass < 2 * dts_pkg::MaxNodes; pass++) begin
      changed = 1'b0;
      for (b = 1; b < n; b++) begin
        have = 1'b0;
        cand = 0;
        for (p = 0; p < n; p++) begin
          if (pred_rows[b][p] && idom_table[p][6]) begin
            if (!have) begin
              cand = p;
              have = 1'b1;
            end else begin
              cand = meet(p, cand);
            end
          end
        end
        if (have) begin
          v = {1'b1, cand[5:0]};
          if (idom_table[b] != v) begin
            idom_table[b] = v;
            changed = 1'b1;
          end
        end
      end
    end
    for (int k = 0; k < n; k++) begin
      w.blk = k[5:0];
      w.reach = idom_table[k][6];
      w.idom = w.reach ? idom_table[k][5:0] : '0;
      w.last = (k + 1 == n);
      idom_queue.push_back(w);
    end
  endtask

  // send one word, hold it until accepted, then update the predictor
  task automatic send_word(logic [1:0] mode, int blk, int prd);
    int gap;
    in_valid <= 1'b1;
    in_mode <= mode;
    in_block <= blk[5:0];
    in_pred_block <= prd[5:0];
    do @(posedge clk); while (!in_ready);
    words_sent++;
    case (mode)
      dts_pkg::MODE_EDGE: pred_rows[blk[5:0]][prd[5:0]] = 1'b1;
      dts_pkg::MODE_CLEAR: for (int i = 0; i < dts_pkg::MaxNodes; i++) pred_rows[i] = '0;
      dts_pkg::MODE_SOLVE: begin
        solves_sent++;
        predict_idoms();
      end
      default: ;
    endcase
    gap = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 60) :
          ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drop valid and let the block drain before touching the register
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (idom_queue.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_count(int value);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_block_count <= value[dts_pkg::CntW-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    node_count = value[dts_pkg::CntW-1:0];
  endtask

  // receiver: random ready, with a counted hold-off when asked
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 30) == 0) ? 1'b0 : ($urandom_range(0, 2) != 0);
    end
  end

  // compare each accepted result word with the oldest expectation
  always @(posedge clk) begin
    dom_word_t e;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (idom_queue.size() == 0) begin
        $display("%0t: unexpected result word blk=%0d idom=%0d", $time,
                 out_block_index, out_immediate_dom);
        errors++;
      end else begin
        e = idom_queue.pop_front();
        if (out_block_index !== e.blk) begin
          $display("%0t: block_index exp %0d got %0d", $time, e.blk, out_block_index);
          errors++;
        end
        if (out_immediate_dom !== e.idom) begin
          $display("%0t: immediate_dom exp %0d got %0d", $time, e.idom, out_immediate_dom);
          errors++;
        end
        if (out_reachable !== e.reach) begin
          $display("%0t: reachable exp %0b got %0b", $time, e.reach, out_reachable);
          errors++;
        end
        if (out_last !== e.last) begin
          $display("%0t: last exp %0b got %0b", $time, e.last, out_last);
          errors++;
        end
      end
    end
  end

  // entry alone after reset
  task automatic test_reset_state();
    send_word(dts_pkg::MODE_SOLVE, 0, 0);
  endtask

  // extremes, odd modes and corner cases
  task automatic test_directed();
    write_count(4);
    send_word(dts_pkg::MODE_EDGE, 1, 0);
    send_word(dts_pkg::MODE_EDGE, 2, 1);
    send_word(dts_pkg::MODE_EDGE, 2, 1);     // duplicate edge
    send_word(dts_pkg::MODE_EDGE, 63, 63);   // beyond the count
    send_word(dts_pkg::MODE_EDGE, 1, 63);
    send_word(ModeUnused, 63, 63);           // unused mode
    send_word(dts_pkg::MODE_SOLVE, 0, 0);    // block 3 unreachable
    send_word(dts_pkg::MODE_EDGE, 3, 2);
    send_word(dts_pkg::MODE_EDGE, 3, 1);
    send_word(dts_pkg::MODE_EDGE, 1, 3);     // back edge
    send_word(dts_pkg::MODE_SOLVE, 63, 63);
    write_count(0);
    send_word(dts_pkg::MODE_SOLVE, 0, 0);    // no results
    write_count(127);                        // treated as the full size
    send_word(dts_pkg::MODE_SOLVE, 0, 0);
    send_word(dts_pkg::MODE_CLEAR, 0, 0);
    write_count(3);
    send_word(dts_pkg::MODE_EDGE, 1, 2);     // not in reverse postorder
    send_word(dts_pkg::MODE_EDGE, 2, 1);
    send_word(dts_pkg::MODE_EDGE, 2, 0);
    send_word(dts_pkg::MODE_SOLVE, 0, 0);
    send_word(dts_pkg::MODE_SOLVE, 0, 0);    // fresh solve on same edges
  endtask

  // one graph: mostly forward edges, a few back edges and noise
  task automatic load_graph(int n, bit noisy);
    int extra;
    send_word(dts_pkg::MODE_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63));
    for (int b = 1; b < n; b++)
      if ($urandom_range(0, 11) != 0)
        send_word(dts_pkg::MODE_EDGE, b, $urandom_range(0, b - 1));
    extra = $urandom_range(0, n / 2 + 1);
    for (int i = 0; i < extra; i++) begin
      if (noisy || $urandom_range(0, 3) == 0)
        send_word(dts_pkg::MODE_EDGE, $urandom_range(0, 63), $urandom_range(0, 63));
      else
        send_word(dts_pkg::MODE_EDGE, $urandom_range(1, n - 1), $urandom_range(0, n - 1));
    end
    if ($urandom_range(0, 9) == 0) send_word(ModeUnused, $urandom_range(0, 63), 0);
  endtask

  task automatic test_random_graphs();
    int n;
    while (words_sent < 420) begin
      n = ($urandom_range(0, 14) == 0) ? 64 : $urandom_range(1, 10);
      load_graph(n, (n <= 8) && ($urandom_range(0, 4) == 0));
      write_count(($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) % 12 : n);
      send_word(dts_pkg::MODE_SOLVE, $urandom_range(0, 63), $urandom_range(0, 63));
    end
  endtask

  // receiver stalls while the sender keeps offering words
  task automatic test_backpressure();
    write_count(12);
    load_graph(12, 1'b0);
    hold_cycles = 600;
    send_word(dts_pkg::MODE_SOLVE, 0, 0);
    for (int i = 0; i < 6; i++) send_word(dts_pkg::MODE_EDGE, $urandom_range(1, 11), 0);
    send_word(dts_pkg::MODE_SOLVE, 0, 0);
  endtask

  initial begin
    for (int i = 0; i < dts_pkg::MaxNodes; i++) begin
      pred_rows[i] = '0;
      idom_table[i] = '0;
    end
    node_count = 1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_directed();
    test_backpressure();
    test_random_graphs();
    wait_idle();
    $display("sent %0d words including %0d solves, checked %0d result words",
             words_sent, solves_sent, results_seen);
    $display("graphs of 0 to 64 blocks, duplicate, stray and back edges, long output stall");
    if (errors == 0 && idom_queue.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("timeout");
    $display("end of test: mismatches");
    $finish;
  end
endmodule
